// ===== src/slsm_pkg.sv =====
// shared types, constants and width helpers for the sorted id list set merge
// no dependencies; imported by every module of the block except slsm_ram
package slsm_pkg;

  // fixed widths of the external fields
  localparam int DOC_ID_W    = 32;
  localparam int MODE_W      = 2;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  // parameter defaults
  localparam int DEFAULT_LIST_DEPTH = 32;
  localparam int DEFAULT_ID_WIDTH   = 32;
  localparam int JOB_QUEUE_DEPTH    = 2;

  // register index of set_mode
  localparam logic REG_SET_MODE = 1'b0;

  // set operation codes; the spare code behaves as intersection
  typedef enum logic [MODE_W-1:0] {
    MODE_INTERSECT = 2'd0,
    MODE_UNION     = 2'd1,
    MODE_DIFF      = 2'd2
  } mode_t;

  // merge engine states
  typedef enum logic {
    BK_IDLE,
    BK_MERGE
  } back_state_t;

  // status of the job queue as seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  // width of a fill count that can hold the depth itself
  function automatic int cnt_w(input int depth);
    return $clog2(depth + 1);
  endfunction

  // width of a store address
  function automatic int adr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // width of one merge job: two counts, overflow flag and mode
  function automatic int job_w(input int depth);
    return 2 * cnt_w(depth) + 1 + MODE_W;
  endfunction

  // number of id bits that survive from the input field
  function automatic int keep_w(input int id_width);
    return (id_width < DOC_ID_W) ? id_width : DOC_ID_W;
  endfunction

endpackage

// ===== src/slsm_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module slsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/slsm_queue.sv =====
// short fifo carrying merge jobs from the loader to the merge engine
// depends on slsm_pkg for the queue status struct and the default depth
module slsm_queue
  import slsm_pkg::*;
#(
  parameter int WIDTH = 16,
  parameter int DEPTH = JOB_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output queue_status_t    status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [FW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign status.empty = (fill == '0);
  assign status.full  = (fill == FW'(DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = slots[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + FW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - FW'(1);
      end
    end
  end

endmodule

// ===== src/slsm_front.sv =====
// loader: accepts list items, fills both stores and issues a merge job per run
// depends on slsm_pkg for widths and parameter defaults
module slsm_front
  import slsm_pkg::*;
#(
  parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH,
  parameter int ID_WIDTH   = DEFAULT_ID_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  // item channel
  input  logic                             item_valid,
  output logic                             item_ready,
  input  logic                             list_sel,
  input  logic [DOC_ID_W-1:0]              doc_id,
  input  logic                             is_last,
  input  logic                             no_element,
  // stall while the stores are being merged
  input  logic                             hold,
  input  logic [MODE_W-1:0]                set_mode,
  // store write ports
  output logic                             wr_a,
  output logic                             wr_b,
  output logic [adr_w(LIST_DEPTH)-1:0]     wr_addr,
  output logic [ID_WIDTH-1:0]              wr_data,
  // job to the merge engine
  output logic                             job_push,
  output logic [job_w(LIST_DEPTH)-1:0]     job_data
);

  localparam int CW = cnt_w(LIST_DEPTH);
  localparam int AW = adr_w(LIST_DEPTH);
  localparam int KW = keep_w(ID_WIDTH);

  typedef struct packed {
    logic [CW-1:0]     count_a;
    logic [CW-1:0]     count_b;
    logic              ovf;
    logic [MODE_W-1:0] mode;
  } job_t;

  logic [CW-1:0] count_a, count_a_next, count_a_upd;
  logic [CW-1:0] count_b, count_b_next, count_b_upd;
  logic          closed_a, closed_a_next, closed_a_upd;
  logic          closed_b, closed_b_next, closed_b_upd;
  logic          overflow_seen, overflow_seen_next, ovf_upd;
  logic          accept;
  logic          take;
  logic          sel_closed;
  logic [CW-1:0] sel_count;
  logic          has_room;
  logic          store_it;
  logic          drop;
  logic          trigger;
  job_t          job;

  assign item_ready = !hold;
  assign accept     = item_valid && item_ready;

  // classify the item against the selected list
  always_comb begin
    sel_closed = list_sel ? closed_b : closed_a;
    sel_count  = list_sel ? count_b : count_a;
    has_room   = (sel_count < CW'(LIST_DEPTH));
    take       = accept && !sel_closed;
    store_it   = take && !no_element && has_room;
    drop       = take && !no_element && !has_room;
  end

  // updated run state after this item
  always_comb begin
    count_a_upd  = count_a + CW'(store_it && !list_sel);
    count_b_upd  = count_b + CW'(store_it && list_sel);
    closed_a_upd = closed_a || (take && !list_sel && is_last);
    closed_b_upd = closed_b || (take && list_sel && is_last);
    ovf_upd      = overflow_seen || drop;
    trigger      = closed_a_upd && closed_b_upd;
  end

  // a run ends once both lists are closed
  always_comb begin
    if (trigger) begin
      count_a_next       = '0;
      count_b_next       = '0;
      closed_a_next      = 1'b0;
      closed_b_next      = 1'b0;
      overflow_seen_next = 1'b0;
    end else begin
      count_a_next       = count_a_upd;
      count_b_next       = count_b_upd;
      closed_a_next      = closed_a_upd;
      closed_b_next      = closed_b_upd;
      overflow_seen_next = ovf_upd;
    end
  end

  // store writes and job
  always_comb begin
    wr_a         = store_it && !list_sel;
    wr_b         = store_it && list_sel;
    wr_addr      = sel_count[AW-1:0];
    wr_data      = ID_WIDTH'(doc_id[KW-1:0]);
    job.count_a  = count_a_upd;
    job.count_b  = count_b_upd;
    job.ovf      = ovf_upd;
    job.mode     = set_mode;
    job_push     = trigger;
    job_data     = job;
  end

  // run state
  always_ff @(posedge clk) begin
    if (rst) begin
      count_a       <= '0;
      count_b       <= '0;
      closed_a      <= 1'b0;
      closed_b      <= 1'b0;
      overflow_seen <= 1'b0;
    end else begin
      count_a       <= count_a_next;
      count_b       <= count_b_next;
      closed_a      <= closed_a_next;
      closed_b      <= closed_b_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule

// ===== src/slsm_back.sv =====
// merge engine: two-pointer walk over both stores and the result output stage
// depends on slsm_pkg for widths, mode codes, states and the queue status
module slsm_back
  import slsm_pkg::*;
#(
  parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH,
  parameter int ID_WIDTH   = DEFAULT_ID_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  // job queue
  input  queue_status_t                    q_status,
  input  logic [job_w(LIST_DEPTH)-1:0]     job_data,
  output logic                             job_pop,
  output logic                             busy,
  // store read ports, data registered in the cycle after the address
  output logic [adr_w(LIST_DEPTH)-1:0]     rd_addr_a,
  output logic [adr_w(LIST_DEPTH)-1:0]     rd_addr_b,
  input  logic [ID_WIDTH-1:0]              rd_data_a,
  input  logic [ID_WIDTH-1:0]              rd_data_b,
  // result channel
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic [DOC_ID_W-1:0]              out_doc_id,
  output logic                             out_valid,
  output logic                             out_last,
  output logic                             overflow
);

  localparam int CW = cnt_w(LIST_DEPTH);
  localparam int AW = adr_w(LIST_DEPTH);
  localparam int KW = keep_w(ID_WIDTH);

  typedef struct packed {
    logic [CW-1:0]     count_a;
    logic [CW-1:0]     count_b;
    logic              ovf;
    logic [MODE_W-1:0] mode;
  } job_t;

  back_state_t       state, state_next;
  job_t              job;
  logic [CW-1:0]     ia, ia_next;
  logic [CW-1:0]     ib, ib_next;
  logic [CW-1:0]     ca, cb;
  logic [MODE_W-1:0] mode;
  logic              run_ovf;
  logic              held_valid;
  logic [ID_WIDTH-1:0] held_id;

  logic              have_a, have_b;
  logic              keep_a_only, keep_b_only, keep_both;
  logic              produce;
  logic [ID_WIDTH-1:0] prod_id;
  logic              adv_a, adv_b;
  logic              finish;
  logic              need_push;
  logic              space;
  logic              go;
  logic              load;

  assign job  = job_t'(job_data);
  assign busy = (state == BK_MERGE);

  // mode decode, the spare code keeps the intersection behaviour
  always_comb begin
    keep_a_only = (mode == MODE_UNION) || (mode == MODE_DIFF);
    keep_b_only = (mode == MODE_UNION);
    keep_both   = (mode != MODE_DIFF);
  end

  // one merge step on the two current heads
  always_comb begin
    have_a  = (ia < ca);
    have_b  = (ib < cb);
    produce = 1'b0;
    prod_id = rd_data_a;
    adv_a   = 1'b0;
    adv_b   = 1'b0;
    finish  = 1'b0;
    if (have_a && have_b) begin
      if (rd_data_a == rd_data_b) begin
        produce = keep_both;
        adv_a   = 1'b1;
        adv_b   = 1'b1;
      end else if (rd_data_a < rd_data_b) begin
        produce = keep_a_only;
        adv_a   = 1'b1;
      end else begin
        produce = keep_b_only;
        prod_id = rd_data_b;
        adv_b   = 1'b1;
      end
    end else if (have_a && keep_a_only) begin
      produce = 1'b1;
      adv_a   = 1'b1;
    end else if (have_b && keep_b_only) begin
      produce = 1'b1;
      prod_id = rd_data_b;
      adv_b   = 1'b1;
    end else begin
      finish  = 1'b1;
    end
  end

  // a held result goes out once a later one exists or the run ends
  always_comb begin
    need_push = (produce && held_valid) || finish;
    space     = !result_valid || result_ready;
    go        = (state == BK_MERGE) && (!need_push || space);
    load      = go && need_push;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_status.empty) begin
          state_next = BK_MERGE;
        end
      end
      BK_MERGE: begin
        if (go && finish) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // pointers and queue pop; store addresses follow the next pointers
  always_comb begin
    job_pop = 1'b0;
    ia_next = ia;
    ib_next = ib;
    unique case (state)
      BK_IDLE: begin
        if (!q_status.empty) begin
          job_pop = 1'b1;
          ia_next = '0;
          ib_next = '0;
        end
      end
      BK_MERGE: begin
        if (go) begin
          ia_next = ia + CW'(adv_a);
          ib_next = ib + CW'(adv_b);
        end
      end
      default: begin
        job_pop = 1'b0;
      end
    endcase
    rd_addr_a = ia_next[AW-1:0];
    rd_addr_b = ib_next[AW-1:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (go) begin
        if (finish) begin
          held_valid <= 1'b0;
        end else if (produce) begin
          held_valid <= 1'b1;
        end
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // job, pointer and result payload registers
  always_ff @(posedge clk) begin
    ia <= ia_next;
    ib <= ib_next;
    if (job_pop) begin
      ca      <= job.count_a;
      cb      <= job.count_b;
      mode    <= job.mode;
      run_ovf <= job.ovf;
    end
    if (go && produce) begin
      held_id <= prod_id;
    end
    if (load) begin
      out_valid <= held_valid;
      out_last  <= finish;
      overflow  <= run_ovf;
      out_doc_id <= held_valid ? DOC_ID_W'(held_id[KW-1:0]) : '0;
    end
  end

endmodule

// ===== src/sorted_id_list_set_merge.sv =====
// top level of the sorted id list set merge: register port, stores and wiring
// depends on slsm_pkg, slsm_ram, slsm_queue, slsm_front and slsm_back
//
// Items of list A and list B are loaded one per cycle while item_ready is
// high into two stores of LIST_DEPTH ids; elements past the depth are dropped
// and reported through overflow. The item that closes the second list hands a
// job over a short queue to the merge engine, which pops it while idle and then
// makes one two-pointer step per cycle, stalling only when a step that pushes
// a result finds the output register still full; each step but the closing
// one consumes at least one element, with at most one result transfer per
// cycle; the store rams are read at the next pointer values so their
// registered read adds no step time. item_ready stays low from the cycle after
// the closing item until the engine has taken its closing step, since the next
// run writes the same stores. Results leave through an output register, so the
// engine keeps going while the last result waits; an empty result is one
// transfer with out_valid clear and out_last set. set_mode lives at byte
// address 0 of the register port; the user must write it only while the block
// is idle, and the block itself does not enforce this.
module sorted_id_list_set_merge
  import slsm_pkg::*;
#(
  parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH,
  parameter int ID_WIDTH   = DEFAULT_ID_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // item channel
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic                  list_sel,
  input  logic [DOC_ID_W-1:0]   doc_id,
  input  logic                  is_last,
  input  logic                  no_element,
  // result channel
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic [DOC_ID_W-1:0]   out_doc_id,
  output logic                  out_valid,
  output logic                  out_last,
  output logic                  overflow
);

  localparam int AW = adr_w(LIST_DEPTH);
  localparam int JW = job_w(LIST_DEPTH);

  logic [MODE_W-1:0] set_mode;
  logic              reg_wr;
  logic              hold;
  logic              busy;
  logic              wr_a, wr_b;
  logic [AW-1:0]     wr_addr;
  logic [ID_WIDTH-1:0] wr_data;
  logic [AW-1:0]     rd_addr_a, rd_addr_b;
  logic [ID_WIDTH-1:0] rd_data_a, rd_data_b;
  logic              job_push, job_pop;
  logic [JW-1:0]     job_in, job_out;
  queue_status_t     q_status;

  // register port, word index taken from the upper address bit
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SET_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      set_mode <= MODE_INTERSECT;
    end else if (reg_wr) begin
      set_mode <= pwdata[MODE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SET_MODE) begin
      prdata = APB_DATA_W'(set_mode);
    end
  end

  // loading waits while a job is queued or being merged
  assign hold = !q_status.empty || busy;

  slsm_front #(
    .LIST_DEPTH (LIST_DEPTH),
    .ID_WIDTH   (ID_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .list_sel   (list_sel),
    .doc_id     (doc_id),
    .is_last    (is_last),
    .no_element (no_element),
    .hold       (hold),
    .set_mode   (set_mode),
    .wr_a       (wr_a),
    .wr_b       (wr_b),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .job_push   (job_push),
    .job_data   (job_in)
  );

  // list stores
  slsm_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (LIST_DEPTH),
    .AW    (AW)
  ) u_store_a (
    .clk   (clk),
    .we    (wr_a),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr_a),
    .rdata (rd_data_a)
  );

  slsm_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (LIST_DEPTH),
    .AW    (AW)
  ) u_store_b (
    .clk   (clk),
    .we    (wr_b),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr_b),
    .rdata (rd_data_b)
  );

  // job queue between loader and merge engine
  slsm_queue #(
    .WIDTH (JW),
    .DEPTH (JOB_QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_in),
    .pop       (job_pop),
    .pop_data  (job_out),
    .status    (q_status)
  );

  slsm_back #(
    .LIST_DEPTH (LIST_DEPTH),
    .ID_WIDTH   (ID_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .job_data     (job_out),
    .job_pop      (job_pop),
    .busy         (busy),
    .rd_addr_a    (rd_addr_a),
    .rd_addr_b    (rd_addr_b),
    .rd_data_a    (rd_data_a),
    .rd_data_b    (rd_data_b),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_doc_id   (out_doc_id),
    .out_valid    (out_valid),
    .out_last     (out_last),
    .overflow     (overflow)
  );

endmodule
